### src/hs1_pkg.sv
// ----------------------------------------------------------------------------
// hs1_pkg
// Types and constants shared by the HMAC-SHA1 engine modules.
// ----------------------------------------------------------------------------
package hs1_pkg;

	localparam int BLOCK_BYTES  = 64;
	localparam int DIGEST_BYTES = 20;

	localparam logic [7:0] IPAD_BYTE = 8'h36;
	localparam logic [7:0] OPAD_BYTE = 8'h5c;
	localparam logic [7:0] PAD_START = 8'h80;

	localparam logic [1:0] ACT_KEY_BYTE = 2'd0;
	localparam logic [1:0] ACT_KEY_END  = 2'd1;
	localparam logic [1:0] ACT_MSG_BYTE = 2'd2;
	localparam logic [1:0] ACT_MSG_END  = 2'd3;

	localparam logic [31:0] SHA1_IV [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	typedef logic [4:0][31:0] hs1_chain_t;

	// byte commands from the sequencer into the SHA-1 core
	typedef struct packed {
		logic       init;
		logic       valid;
		logic       count;
		logic [7:0] data;
	} hs1_feed_t;

	// core status back to the sequencer
	typedef struct packed {
		logic        busy;
		logic [5:0]  pos;
		logic [60:0] len;
		logic        wrap;
	} hs1_stat_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_KEY  = 3'b010,
		PH_MSG  = 3'b100
	} hs1_phase_t;

	typedef enum logic [9:0] {
		S_READY     = 10'b0000000001,
		S_LONG_XFER = 10'b0000000010,
		S_LONG_LAST = 10'b0000000100,
		S_PAD_KEY   = 10'b0000001000,
		S_FINAL     = 10'b0000010000,
		S_DRAIN     = 10'b0000100000,
		S_KEYLOAD   = 10'b0001000000,
		S_OUTER     = 10'b0010000000,
		S_INNER     = 10'b0100000000,
		S_OUT       = 10'b1000000000
	} hs1_state_t;

	// big-endian byte of a 32-bit word, sel 0 is the top byte
	function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] sel);
		logic [7:0] b;
		case (sel)
			2'd0:    b = w[31:24];
			2'd1:    b = w[23:16];
			2'd2:    b = w[15:8];
			default: b = w[7:0];
		endcase
		return b;
	endfunction

endpackage

### src/hs1_if.sv
// ----------------------------------------------------------------------------
// hs1_in_if / hs1_out_if
// Valid/ready channels for input items and digest results.
// ----------------------------------------------------------------------------
interface hs1_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] data_byte;

	modport source (output valid, output action, output data_byte, input ready);
	modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface hs1_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	logic        error;

	modport source (output valid, output digest_word, output word_index,
		output last_word, output error, input ready);
	modport sink   (input valid, input digest_word, input word_index,
		input last_word, input error, output ready);
endinterface

### src/hs1_ram.sv
// ----------------------------------------------------------------------------
// hs1_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hs1_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/hs1_core.sv
// ----------------------------------------------------------------------------
// hs1_core
// SHA-1 block buffer and round unit: takes bytes, runs one round per cycle.
// ----------------------------------------------------------------------------
module hs1_core (
	input  logic              clk,
	input  logic              arst_n,
	input  hs1_pkg::hs1_feed_t feed,
	output hs1_pkg::hs1_stat_t stat,
	output hs1_pkg::hs1_chain_t chain
);
	import hs1_pkg::*;

	logic [511:0]  blk_q;
	hs1_chain_t    chain_q;
	logic [31:0]   a_q, b_q, c_q, d_q, e_q;
	logic [6:0]    round_q;
	logic          busy_q;
	logic [5:0]    pos_q;
	logic [60:0]   len_q;

	logic [31:0] w0, w2, w8, w13, w_new, f, k, t;
	logic        take;

	assign take = feed.valid && !busy_q && !feed.init;

	assign w0  = blk_q[511:480];
	assign w2  = blk_q[447:416];
	assign w8  = blk_q[255:224];
	assign w13 = blk_q[95:64];

	always_comb begin
		w_new = w13 ^ w8 ^ w2 ^ w0;
		w_new = {w_new[30:0], w_new[31]};
		if (round_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = 32'h5A827999;
		end else if (round_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = 32'h6ED9EBA1;
		end else if (round_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = 32'h8F1BBCDC;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = 32'hCA62C1D6;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			round_q <= '0;
			pos_q   <= '0;
			len_q   <= '0;
			for (int i = 0; i < 5; i++) chain_q[i] <= SHA1_IV[i];
		end else if (feed.init) begin
			pos_q <= '0;
			len_q <= '0;
			for (int i = 0; i < 5; i++) chain_q[i] <= SHA1_IV[i];
		end else if (busy_q) begin
			if (round_q == 7'd80) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
				busy_q     <= 1'b0;
			end else begin
				round_q <= round_q + 7'd1;
			end
		end else if (take) begin
			pos_q <= pos_q + 6'd1;
			if (feed.count) begin
				len_q <= len_q + 61'd1;
			end
			if (pos_q == 6'd63) begin
				busy_q  <= 1'b1;
				round_q <= '0;
			end
		end
	end

	// datapath: block window and working variables
	always_ff @(posedge clk) begin
		if (busy_q && round_q != 7'd80) begin
			blk_q <= {blk_q[479:0], w_new};
			e_q   <= d_q;
			d_q   <= c_q;
			c_q   <= {b_q[1:0], b_q[31:2]};
			b_q   <= a_q;
			a_q   <= t;
		end else if (take) begin
			blk_q <= {blk_q[503:0], feed.data};
			if (pos_q == 6'd63) begin
				a_q <= chain_q[0];
				b_q <= chain_q[1];
				c_q <= chain_q[2];
				d_q <= chain_q[3];
				e_q <= chain_q[4];
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.pos  = pos_q;
	assign stat.len  = len_q;
	assign stat.wrap = take && feed.count && (&len_q);
	assign chain     = chain_q;

endmodule

### src/hmac_sha1_engine.sv
// Items: a key or message byte is taken when ready; a byte that closes a 64-byte block
// starts 80 SHA-1 rounds and one chaining add in the core, one round a cycle.
// Key end: the ipad block is fed from the key RAM, each byte read before it is fed,
// and hashed; a long key first adds its padding and reloads its digest into the RAM.
// Message end: padding, opad block, 20 inner digest bytes and final padding, then
// five result transfers, or one error transfer. Reset: idle, IV loaded.
// ----------------------------------------------------------------------------
// hmac_sha1_engine
// HMAC-SHA1 sequencer around a shared SHA-1 round unit and a 64-byte key RAM.
// ----------------------------------------------------------------------------
module hmac_sha1_engine (
	input  logic            clk,
	input  logic            arst_n,
	hs1_in_if.sink          item,
	hs1_out_if.source       result
);
	import hs1_pkg::*;

	localparam logic [6:0] KEY_CAP = 7'(BLOCK_BYTES);
	localparam logic [6:0] DIG_LEN = 7'(DIGEST_BYTES);
	localparam logic [5:0] DIG_LAST = 6'(DIGEST_BYTES - 1);

	hs1_state_t  state_q, ret_q;
	hs1_phase_t  phase_q;
	logic [6:0]  key_count_q;
	logic        key_long_q, ovf_q;
	logic [5:0]  idx_q;
	logic        rd_pend_q;
	logic [7:0]  pad_q, byte_q;
	logic        outer_q, err_q;
	logic [2:0]  out_idx_q;
	logic        s80_q, lm_q;
	logic [63:0] len_bits_q;
	hs1_chain_t  inner_q;

	hs1_feed_t   feed;
	hs1_stat_t   stat;
	hs1_chain_t  chain;

	logic        ram_we, ram_re;
	logic [5:0]  ram_waddr, ram_raddr;
	logic [7:0]  ram_wdata, ram_rdata;

	logic        acc, new_run, eff_long, len_byte;
	logic [6:0]  eff_count;
	logic [7:0]  key_byte, chain_byte, inner_byte, fin_byte;

	hs1_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.feed   (feed),
		.stat   (stat),
		.chain  (chain)
	);

	hs1_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_key_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign item.ready = (state_q == S_READY) && !stat.busy;
	assign acc        = item.valid && item.ready;
	assign new_run    = (phase_q != PH_KEY);
	assign eff_count  = new_run ? 7'd0 : key_count_q;
	assign eff_long   = !new_run && key_long_q;

	// entries at or above the fill count read as zero
	assign key_byte   = (({1'b0, idx_q} < key_count_q) ? ram_rdata : 8'h00) ^ pad_q;
	assign chain_byte = word_byte(chain[idx_q[4:2]], idx_q[1:0]);
	assign inner_byte = word_byte(inner_q[idx_q[4:2]], idx_q[1:0]);
	assign len_byte   = lm_q || (stat.pos == 6'd56);
	assign fin_byte   = !s80_q ? PAD_START : (len_byte ? len_bits_q[63:56] : 8'h00);

	always_comb begin
		feed      = '0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = eff_count[5:0];
		ram_raddr = idx_q;
		ram_wdata = item.data_byte;
		unique case (state_q)
			S_READY: begin
				if (acc) begin
					case (item.action)
						ACT_KEY_BYTE: begin
							feed.init = new_run;
							if (eff_long) begin
								feed.valid = 1'b1;
								feed.count = 1'b1;
								feed.data  = item.data_byte;
							end else if (eff_count < KEY_CAP) begin
								ram_we = 1'b1;
							end
						end
						ACT_KEY_END: begin
							feed.init = new_run || !key_long_q;
						end
						ACT_MSG_BYTE: begin
							if (phase_q == PH_MSG) begin
								feed.valid = 1'b1;
								feed.count = 1'b1;
								feed.data  = item.data_byte;
							end
						end
						default: ;
					endcase
				end
			end
			S_LONG_XFER, S_PAD_KEY: begin
				if (!rd_pend_q) begin
					ram_re = 1'b1;
				end else if (!stat.busy) begin
					feed.valid = 1'b1;
					feed.count = 1'b1;
					feed.data  = key_byte;
				end
			end
			S_LONG_LAST: begin
				if (!stat.busy) begin
					feed.valid = 1'b1;
					feed.count = 1'b1;
					feed.data  = byte_q;
				end
			end
			S_FINAL: begin
				if (!stat.busy) begin
					feed.valid = 1'b1;
					feed.data  = fin_byte;
				end
			end
			S_KEYLOAD: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = chain_byte;
				feed.init = (idx_q == DIG_LAST);
			end
			S_OUTER: begin
				feed.init = 1'b1;
			end
			S_INNER: begin
				if (!stat.busy) begin
					feed.valid = 1'b1;
					feed.count = 1'b1;
					feed.data  = inner_byte;
				end
			end
			S_DRAIN, S_OUT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_READY;
			ret_q       <= S_OUT;
			phase_q     <= PH_IDLE;
			key_count_q <= '0;
			key_long_q  <= 1'b0;
			ovf_q       <= 1'b0;
			idx_q       <= '0;
			rd_pend_q   <= 1'b0;
			pad_q       <= '0;
			byte_q      <= '0;
			outer_q     <= 1'b0;
			err_q       <= 1'b0;
			out_idx_q   <= '0;
			s80_q       <= 1'b0;
			lm_q        <= 1'b0;
			len_bits_q  <= '0;
			inner_q     <= '0;
		end else begin
			unique case (state_q)
				S_READY: begin
					if (acc) begin
						case (item.action)
							ACT_KEY_BYTE: begin
								if (new_run) begin
									phase_q    <= PH_KEY;
									ovf_q      <= 1'b0;
									key_long_q <= 1'b0;
								end
								if (!eff_long) begin
									if (eff_count < KEY_CAP) begin
										key_count_q <= eff_count + 7'd1;
									end else begin
										// key overflows the block: hash it instead
										key_long_q <= 1'b1;
										idx_q      <= '0;
										rd_pend_q  <= 1'b0;
										pad_q      <= 8'h00;
										byte_q     <= item.data_byte;
										state_q    <= S_LONG_XFER;
									end
								end
							end
							ACT_KEY_END: begin
								if (new_run) begin
									ovf_q       <= 1'b0;
									key_long_q  <= 1'b0;
									key_count_q <= '0;
								end
								phase_q <= PH_MSG;
								if (eff_long) begin
									ret_q   <= S_KEYLOAD;
									state_q <= S_FINAL;
								end else begin
									idx_q     <= '0;
									rd_pend_q <= 1'b0;
									pad_q     <= IPAD_BYTE;
									outer_q   <= 1'b0;
									state_q   <= S_PAD_KEY;
								end
							end
							ACT_MSG_END: begin
								phase_q   <= PH_IDLE;
								out_idx_q <= '0;
								if (phase_q != PH_MSG || ovf_q) begin
									err_q   <= 1'b1;
									state_q <= S_OUT;
								end else begin
									err_q   <= 1'b0;
									ret_q   <= S_OUTER;
									state_q <= S_FINAL;
								end
							end
							default: ;
						endcase
					end
				end
				S_LONG_XFER, S_PAD_KEY: begin
					if (!rd_pend_q) begin
						rd_pend_q <= 1'b1;
					end else if (!stat.busy) begin
						rd_pend_q <= 1'b0;
						idx_q     <= idx_q + 6'd1;
						if (idx_q == 6'(BLOCK_BYTES - 1)) begin
							if (state_q == S_LONG_XFER) begin
								state_q <= S_LONG_LAST;
							end else if (outer_q) begin
								state_q <= S_INNER;
							end else begin
								state_q <= S_READY;
							end
						end
					end
				end
				S_LONG_LAST: begin
					if (!stat.busy) begin
						state_q <= S_READY;
					end
				end
				S_FINAL: begin
					if (!stat.busy) begin
						if (!s80_q) begin
							s80_q      <= 1'b1;
							len_bits_q <= {stat.len, 3'b000};
						end else if (len_byte) begin
							lm_q       <= 1'b1;
							len_bits_q <= {len_bits_q[55:0], 8'h00};
							if (stat.pos == 6'd63) begin
								state_q <= S_DRAIN;
							end
						end
					end
				end
				S_DRAIN: begin
					if (!stat.busy) begin
						s80_q   <= 1'b0;
						lm_q    <= 1'b0;
						idx_q   <= '0;
						state_q <= ret_q;
					end
				end
				S_KEYLOAD: begin
					if (idx_q == DIG_LAST) begin
						key_count_q <= DIG_LEN;
						idx_q       <= '0;
						rd_pend_q   <= 1'b0;
						pad_q       <= IPAD_BYTE;
						outer_q     <= 1'b0;
						state_q     <= S_PAD_KEY;
					end else begin
						idx_q <= idx_q + 6'd1;
					end
				end
				S_OUTER: begin
					inner_q   <= chain;
					idx_q     <= '0;
					rd_pend_q <= 1'b0;
					pad_q     <= OPAD_BYTE;
					outer_q   <= 1'b1;
					state_q   <= S_PAD_KEY;
				end
				S_INNER: begin
					if (!stat.busy) begin
						idx_q <= idx_q + 6'd1;
						if (idx_q == DIG_LAST) begin
							ret_q   <= S_OUT;
							state_q <= S_FINAL;
						end
					end
				end
				S_OUT: begin
					if (result.ready) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (err_q || out_idx_q == 3'd4) begin
							state_q <= S_READY;
						end
					end
				end
				default: state_q <= S_READY;
			endcase
			if (stat.wrap) begin
				ovf_q <= 1'b1;
			end
		end
	end

	assign result.valid       = (state_q == S_OUT);
	assign result.digest_word = err_q ? 32'h0 : chain[out_idx_q];
	assign result.word_index  = err_q ? 3'd0 : out_idx_q;
	assign result.last_word   = err_q || (out_idx_q == 3'd4);
	assign result.error       = err_q;

	a_ready_idle_core: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> !stat.busy)
		else $error("input ready while round unit busy");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.error |-> result.digest_word == 32'h0 && result.last_word)
		else $error("error result carries digest data");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.error |-> result.last_word == (result.word_index == 3'd4))
		else $error("last word flag out of step with index");

	a_key_count: assert property (@(posedge clk) disable iff (!arst_n)
		key_count_q <= KEY_CAP)
		else $error("key fill count beyond block size");

endmodule
